### src/fcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants of the fiber coincidence counter.
// ----------------------------------------------------------------------------
package fcc_pkg;

   localparam int NUM_FIBERS_DEF = 64;
   localparam int FIBER_W        = 6;
   localparam int TIME_W         = 32;
   localparam int AMP_W          = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [AMP_W-1:0]      THRESHOLD_RST = 16'd32;
   localparam logic [CSR_DATA_W-1:0] WINDOW_RST    = 16'd200;
   localparam logic [CSR_DATA_W-1:0] GAP_RST       = 16'd200;
   localparam logic [TIME_W-1:0]     COUNT_MAX     = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_GAP       = 2'd2,
      CSR_SPARE     = 2'd3
   } csr_index_type;

   // Live configuration, front to back.
   typedef struct packed {
      logic [CSR_DATA_W-1:0] window;
      logic [CSR_DATA_W-1:0] gap;
   } cfg_type;

   // Classified pulse waiting in the queue.
   typedef struct packed {
      logic [FIBER_W-1:0] fiber;
      logic               channel;
      logic [TIME_W-1:0]  pulse_time;
      logic [TIME_W-1:0]  latest;
      logic               in_range;
      logic               qualify;
   } item_type;

   // Per-fiber record; an entry never written reads as all zero (unarmed).
   typedef struct packed {
      logic              armed_channel;
      logic [TIME_W-1:0] armed_time;
      logic              coinc_valid;
      logic [TIME_W-1:0] coinc_time;
      logic [TIME_W-1:0] hit_count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
   localparam int ITEM_W  = $bits(item_type);

endpackage

### src/fcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fcc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_queue
// Short in-order queue of classified pulses between front and back.
// ----------------------------------------------------------------------------
module fcc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fcc_pkg::item_type push_item,
   input  logic              pop,
   output fcc_pkg::item_type head_item,
   output logic              empty,
   output logic              full
);
   import fcc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign full      = (32'(count_ff) == QUEUE_DEPTH);

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue pushed while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH) else $error("queue count overflow");

endmodule

### src/fcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_front
// Takes pulses, holds configuration and latest time, classifies each pulse.
// ----------------------------------------------------------------------------
module fcc_front #(
   parameter int NUM_FIBERS = fcc_pkg::NUM_FIBERS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [fcc_pkg::FIBER_W-1:0]          fiber,
   input  logic                                 end_channel,
   input  logic [fcc_pkg::TIME_W-1:0]           pulse_time,
   input  logic [fcc_pkg::AMP_W-1:0]            amplitude,
   input  logic                                 csr_write,
   input  fcc_pkg::csr_index_type               csr_index,
   input  logic [fcc_pkg::CSR_DATA_W-1:0]       csr_data,
   output fcc_pkg::item_type                    item,
   output fcc_pkg::cfg_type                     cfg
);
   import fcc_pkg::*;

   logic [AMP_W-1:0]      threshold_ff;
   logic [CSR_DATA_W-1:0] window_ff;
   logic [CSR_DATA_W-1:0] gap_ff;
   logic [TIME_W-1:0]     max_time_ff, max_time_in;

   assign max_time_in = (pulse_time > max_time_ff) ? pulse_time : max_time_ff;

   always_comb begin
      item.fiber      = fiber;
      item.channel    = end_channel;
      item.pulse_time = pulse_time;
      item.latest     = max_time_in;
      item.in_range   = (32'(fiber) < NUM_FIBERS);
      item.qualify    = (amplitude > threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         window_ff    <= WINDOW_RST;
         gap_ff       <= GAP_RST;
         max_time_ff  <= '0;
      end else begin
         if (accept) begin
            max_time_ff <= max_time_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_THRESHOLD: threshold_ff <= csr_data;
               CSR_WINDOW:    window_ff    <= csr_data;
               CSR_GAP:       gap_ff       <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign cfg.window = window_ff;
   assign cfg.gap    = gap_ff;

endmodule

### src/fcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_back
// Per-fiber read-modify-write of the coincidence record, one item at a time.
// ----------------------------------------------------------------------------
module fcc_back #(
   parameter int NUM_FIBERS = fcc_pkg::NUM_FIBERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcc_pkg::cfg_type              cfg,
   input  fcc_pkg::item_type             head_item,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [fcc_pkg::FIBER_W-1:0]   rsp_fiber_echo,
   output logic                          rsp_coincidence,
   output logic [fcc_pkg::TIME_W-1:0]    rsp_fiber_count,
   output logic [fcc_pkg::TIME_W-1:0]    rsp_latest_time
);
   import fcc_pkg::*;

   localparam int IDX_W = (NUM_FIBERS > 1) ? $clog2(NUM_FIBERS) : 1;

   typedef enum logic {
      ST_FETCH,
      ST_EXEC
   } state_type;

   state_type             state_ff;
   item_type              item_ff;
   logic                  rd_valid_ff;
   logic [NUM_FIBERS-1:0] written_ff;
   logic                  strobe_ff;
   logic [FIBER_W-1:0]    fiber_echo_ff;
   logic                  coincidence_ff;
   logic [TIME_W-1:0]     fiber_count_ff;
   logic [TIME_W-1:0]     latest_time_ff;

   logic [IDX_W-1:0]      rd_idx, wr_idx;
   logic [ENTRY_W-1:0]    rd_data;
   entry_type             entry, entry_in;
   logic signed [TIME_W:0] d_arm, d_coinc;
   logic                  window_hit, rearm_ok, hit_in, wr_en;

   assign rd_idx = IDX_W'(head_item.fiber);
   assign wr_idx = IDX_W'(item_ff.fiber);
   assign pop    = (state_ff == ST_FETCH) && !empty;

   fcc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_FIBERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (entry_in),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   // Never-written entries read as unarmed, all zero.
   assign entry = rd_valid_ff ? entry_type'(rd_data) : '0;

   assign d_arm   = $signed({1'b0, item_ff.pulse_time}) - $signed({1'b0, entry.armed_time});
   assign d_coinc = $signed({1'b0, item_ff.pulse_time}) - $signed({1'b0, entry.coinc_time});
   assign window_hit = (d_arm < $signed({{(TIME_W + 1 - CSR_DATA_W){1'b0}}, cfg.window}))
                       && (entry.armed_channel != item_ff.channel);
   assign rearm_ok   = !entry.coinc_valid ||
                       (d_coinc > $signed({{(TIME_W + 1 - CSR_DATA_W){1'b0}}, cfg.gap}));

   always_comb begin
      entry_in = entry;
      hit_in   = 1'b0;
      if (!rd_valid_ff) begin
         entry_in.armed_time    = item_ff.pulse_time;
         entry_in.armed_channel = item_ff.channel;
      end else if (window_hit) begin
         entry_in.coinc_valid = 1'b1;
         entry_in.coinc_time  = item_ff.pulse_time;
         if (entry.hit_count != COUNT_MAX) begin
            entry_in.hit_count = entry.hit_count + 1'b1;
         end
         hit_in = 1'b1;
      end else if (rearm_ok) begin
         entry_in.armed_time    = item_ff.pulse_time;
         entry_in.armed_channel = item_ff.channel;
      end
      wr_en = (state_ff == ST_EXEC) && item_ff.in_range && item_ff.qualify;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FETCH;
         strobe_ff  <= 1'b0;
         written_ff <= '0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_FETCH: begin
               if (pop) begin
                  item_ff     <= head_item;
                  rd_valid_ff <= written_ff[rd_idx];
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (wr_en) begin
                  written_ff[wr_idx] <= 1'b1;
               end
               strobe_ff      <= 1'b1;
               fiber_echo_ff  <= item_ff.fiber;
               coincidence_ff <= wr_en && hit_in;
               if (!item_ff.in_range) begin
                  fiber_count_ff <= '0;
               end else if (item_ff.qualify) begin
                  fiber_count_ff <= entry_in.hit_count;
               end else begin
                  fiber_count_ff <= entry.hit_count;
               end
               latest_time_ff <= item_ff.latest;
               state_ff       <= ST_FETCH;
            end
            default: state_ff <= ST_FETCH;
         endcase
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_fiber_echo  = fiber_echo_ff;
   assign rsp_coincidence = coincidence_ff;
   assign rsp_fiber_count = fiber_count_ff;
   assign rsp_latest_time = latest_time_ff;

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EXEC)) else $error("result without execute");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back result strobes");
   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_coincidence) |-> (rsp_fiber_count != '0))
      else $error("coincidence with zero count");

endmodule

### src/fiber_coincidence_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiber_coincidence_counter
// Counts two-ended pulse coincidences per fiber in a time-ordered stream.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------
//  request  | in        | start & !busy              | req_fiber, req_end_channel,
//           |           |                            | req_pulse_time, req_amplitude
//  response | out       | rsp_strobe, one cycle      | rsp_fiber_echo, rsp_coincidence,
//           |           |                            | rsp_fiber_count, rsp_latest_time
//  csr      | in        | csr_valid & csr_ready      | csr_index, csr_data
//
//  Back end: each item passes a fetch state (record read from the RAM), then
//    an execute state (update and write); a new item is fetched only after
//    that. The result strobe is registered at the end of the execute state.
//  Reset: synchronous, active high; per-fiber valid bits clear at once, so
//    there is no clearing pass. Configuration returns to 32 / 200 / 200.
//  Stalls: busy rises while the two-entry queue is full. The receiver cannot
//    stall; every item gives exactly one result strobe.
//  csr_ready is always high; writes to the spare index are ignored.
//
module fiber_coincidence_counter #(
   parameter int NUM_FIBERS = fcc_pkg::NUM_FIBERS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [fcc_pkg::FIBER_W-1:0]      req_fiber,
   input  logic                             req_end_channel,
   input  logic [fcc_pkg::TIME_W-1:0]       req_pulse_time,
   input  logic [fcc_pkg::AMP_W-1:0]        req_amplitude,
   // response channel
   output logic                             rsp_strobe,
   output logic [fcc_pkg::FIBER_W-1:0]      rsp_fiber_echo,
   output logic                             rsp_coincidence,
   output logic [fcc_pkg::TIME_W-1:0]       rsp_fiber_count,
   output logic [fcc_pkg::TIME_W-1:0]       rsp_latest_time,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fcc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fcc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fcc_pkg::*;

   logic     accept;
   logic     q_full, q_empty, q_pop;
   item_type new_item, head_item;
   cfg_type  cfg;

   assign busy      = q_full;
   assign accept    = start && !q_full;
   assign csr_ready = 1'b1;

   // Front end: configuration, latest time, range and amplitude checks.
   fcc_front #(
      .NUM_FIBERS (NUM_FIBERS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .fiber       (req_fiber),
      .end_channel (req_end_channel),
      .pulse_time  (req_pulse_time),
      .amplitude   (req_amplitude),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index_type'(csr_index)),
      .csr_data    (csr_data),
      .item        (new_item),
      .cfg         (cfg)
   );

   // Items stay in order; latest time was already resolved at acceptance.
   fcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (new_item),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Back end: per-fiber record update and result generation.
   fcc_back #(
      .NUM_FIBERS (NUM_FIBERS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_item       (head_item),
      .empty           (q_empty),
      .pop             (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_fiber_echo  (rsp_fiber_echo),
      .rsp_coincidence (rsp_coincidence),
      .rsp_fiber_count (rsp_fiber_count),
      .rsp_latest_time (rsp_latest_time)
   );

endmodule
